>>> src/lpht_pkg.sv
// Package: shared types and constants of the linear probe hash table.
`timescale 1ns / 1ps

package lpht_pkg;

    // Field widths of one request
    localparam int REGION_W  = 7;
    localparam int LETTERS_W = 24;
    localparam int SER_W     = 10;
    localparam int KEY_W     = REGION_W + LETTERS_W + SER_W;

    // Result field widths
    localparam int SLOT_OUT_W  = 6;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_DELETE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_STORED    = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_COMMIT
    } t_state;

endpackage

>>> src/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/lpht_mod.sv
// Home slot unit: serial number modulo SLOTS by reciprocal multiplication, then one correction step.
`timescale 1ns / 1ps

module lpht_mod import lpht_pkg::*; #(
    parameter int SLOTS = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [SER_W-1:0]         i_serial,
    output logic                     o_done,
    output logic [$clog2(SLOTS)-1:0] o_home
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int PROD_W = 2 * SER_W;
    // Reciprocal rounded down: the quotient estimate is low by at most one
    localparam logic [SER_W-1:0] RECIP = SER_W'((1 << SER_W) / SLOTS);
    localparam logic [SER_W-1:0] MODV  = SER_W'(SLOTS);

    logic             r_stage1;
    logic             r_stage2;
    logic             r_done;
    logic [SER_W-1:0] r_ser;
    logic [SER_W-1:0] r_quot;
    logic [IDX_W-1:0] r_rem;

    logic [PROD_W-1:0] prod;
    logic [SER_W-1:0]  quot_est;
    logic [SER_W-1:0]  back;
    logic [SER_W-1:0]  rem_est;
    logic [IDX_W-1:0]  n_rem;

    // Estimate the quotient from the held serial number
    always_comb begin
        prod     = PROD_W'(r_ser) * PROD_W'(RECIP);
        quot_est = prod[PROD_W-1:SER_W];
    end

    // Form the remainder of the estimate, subtract the modulus once if it still fits
    always_comb begin
        back    = r_quot * MODV;
        rem_est = r_ser - back;
        n_rem   = (rem_est >= MODV) ? IDX_W'(rem_est - MODV) : IDX_W'(rem_est);
    end

    // Advance the stage flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage1 <= 1'b0;
            r_stage2 <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_stage1 <= i_start;
            r_stage2 <= r_stage1;
            r_done   <= r_stage2;
        end
    end

    // Hold the serial, then the quotient estimate, then the remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ser <= i_serial;
        end
        if (r_stage1) begin
            r_quot <= quot_est;
        end
        if (r_stage2) begin
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_home = r_rem;

endmodule

>>> src/linear_probe_hash_table_core.sv
// Top level: open-addressing hash table with linear probing over a key RAM.
`timescale 1ns / 1ps

// Hash table of SLOTS entries keyed by region code, three letters and a serial
// number. Each request inserts a key into the first free slot or deletes the
// first matching key, probing upward from slot (serial mod SLOTS) with wrap,
// and returns one result: slot, status and the number of occupied slots.
// Keys live in a RAM with registered read; valid bits are flops cleared by
// reset, so no clearing pass is needed. A request is accepted in S_IDLE, finds
// its home slot in S_HASH (reciprocal multiply, then one correction step),
// makes p probes in S_PROBE (one RAM read per cycle, 1 <= p <= SLOTS)
// and then commits in S_COMMIT. A new request
// is accepted while the previous result still waits in the output register.

module linear_probe_hash_table_core import lpht_pkg::*; #(
    parameter int SLOTS = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_action,
    input  logic [REGION_W-1:0]    i_region_code,
    input  logic [LETTERS_W-1:0]   i_letter_triplet,
    input  logic [SER_W-1:0]       i_serial_number,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [SLOT_OUT_W-1:0]  o_slot_index,
    output logic [1:0]             o_status,
    output logic [COUNT_OUT_W-1:0] o_occupied_count
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] NUM_SLOTS = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(SLOTS - 1);

    t_state r_state, n_state;

    // Request registers
    t_action          r_act;
    logic [KEY_W-1:0] r_key;

    // Probe issue and check stages
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0] r_issued, n_issued;
    logic             r_chk_v, n_chk_v;
    logic [IDX_W-1:0] r_chk_ptr;
    logic             r_chk_last;
    logic             r_hit, n_hit;
    logic [IDX_W-1:0] r_slot, n_slot;

    // Table state
    logic [SLOTS-1:0] r_valid, n_valid;
    logic [CNT_W-1:0] r_count, n_count;

    // Output register
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_slot;
    t_status             r_out_status, n_status;
    logic [CNT_W-1:0]    r_out_count;

    // Control outputs of the state machine
    logic in_xfer;
    logic hash_start;
    logic probe_en;
    logic issue;
    logic commit_go;

    logic             mod_done;
    logic [IDX_W-1:0] mod_home;
    logic [KEY_W-1:0] rd_key;
    logic             chk_match;
    logic             ram_we;

    lpht_mod #(
        .SLOTS (SLOTS)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_serial (i_serial_number),
        .o_done   (mod_done),
        .o_home   (mod_home)
    );

    lpht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_key),
        .i_re    (issue),
        .i_raddr (r_ptr),
        .o_rdata (rd_key)
    );

    // State machine outputs
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        in_xfer    = i_in_valid && o_in_ready;
        hash_start = in_xfer;
        probe_en   = (r_state == S_PROBE);
        issue      = probe_en && (r_issued != NUM_SLOTS);
        commit_go  = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);
    end

    // Probe hit test on the check stage
    always_comb begin
        if (r_act == ACT_DELETE) begin
            chk_match = r_valid[r_chk_ptr] && (rd_key == r_key);
        end else begin
            chk_match = !r_valid[r_chk_ptr];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_HASH;
            end
            S_HASH: begin
                if (mod_done) n_state = S_PROBE;
            end
            S_PROBE: begin
                if (r_chk_v && (chk_match || r_chk_last)) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (commit_go) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Probe pointer, issue count and result of the search
    always_comb begin
        n_ptr    = r_ptr;
        n_issued = r_issued;
        n_chk_v  = 1'b0;
        n_hit    = r_hit;
        n_slot   = r_slot;
        if (r_state == S_HASH) begin
            n_ptr    = mod_home;
            n_issued = '0;
        end
        if (issue) begin
            n_ptr    = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
            n_issued = r_issued + 1'b1;
            n_chk_v  = 1'b1;
        end
        if (probe_en && r_chk_v) begin
            if (chk_match) begin
                n_hit   = 1'b1;
                n_slot  = r_chk_ptr;
                n_chk_v = 1'b0;
            end else if (r_chk_last) begin
                n_hit   = 1'b0;
                n_slot  = '0;
                n_chk_v = 1'b0;
            end
        end
    end

    // Commit: update valid bits and count, pick the status
    always_comb begin
        n_valid  = r_valid;
        n_count  = r_count;
        n_status = (r_act == ACT_DELETE) ? ST_NOT_FOUND : ST_FULL;
        if (r_hit) begin
            if (r_act == ACT_DELETE) begin
                n_valid[r_slot] = 1'b0;
                n_count         = r_count - 1'b1;
                n_status        = ST_REMOVED;
            end else begin
                n_valid[r_slot] = 1'b1;
                n_count         = r_count + 1'b1;
                n_status        = ST_STORED;
            end
        end
    end

    assign ram_we = commit_go && r_hit && (r_act == ACT_INSERT);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chk_v     <= 1'b0;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk_v <= n_chk_v;
            if (commit_go) begin
                r_valid     <= n_valid;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_act <= t_action'(i_action);
            r_key <= {i_region_code, i_letter_triplet, i_serial_number};
        end
        r_ptr      <= n_ptr;
        r_issued   <= n_issued;
        r_hit      <= n_hit;
        r_slot     <= n_slot;
        if (issue) begin
            r_chk_ptr  <= r_ptr;
            r_chk_last <= (r_issued == LAST_CNT);
        end
        if (commit_go) begin
            r_out_slot   <= r_hit ? r_slot : '0;
            r_out_status <= n_status;
            r_out_count  <= n_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_slot_index     = SLOT_OUT_W'(r_out_slot);
    assign o_status         = r_out_status;
    assign o_occupied_count = COUNT_OUT_W'(r_out_count);

endmodule

>>> tb/sv/testbench.sv
// Testbench: self-checking stimulus and checker for linear_probe_hash_table_core.
`timescale 1ns / 1ps

module testbench import lpht_pkg::*; ();

    localparam int TABLE_SLOTS = 7;
    localparam int CLK_HALF    = 10;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct {
        logic [SLOT_OUT_W-1:0]  slot;
        t_status                status;
        logic [COUNT_OUT_W-1:0] count;
    } t_outcome;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic                   i_action;
    logic [REGION_W-1:0]    i_region_code;
    logic [LETTERS_W-1:0]   i_letter_triplet;
    logic [SER_W-1:0]       i_serial_number;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [SLOT_OUT_W-1:0]  o_slot_index;
    logic [1:0]             o_status;
    logic [COUNT_OUT_W-1:0] o_occupied_count;

    // Shadow copy of the table contents, updated in transfer order
    logic     table_valid [TABLE_SLOTS];
    t_key     table_key   [TABLE_SLOTS];
    int       table_count;
    t_outcome queued_outcomes [$];

    int error_count;
    int sink_hold_cycles;
    bit sender_steady;
    bit sink_steady;

    linear_probe_hash_table_core #(
        .SLOTS(TABLE_SLOTS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_region_code    (i_region_code),
        .i_letter_triplet (i_letter_triplet),
        .i_serial_number  (i_serial_number),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_slot_index     (o_slot_index),
        .o_status         (o_status),
        .o_occupied_count (o_occupied_count)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // End the run if traffic stalls for good
    initial begin
        #40_000_000;
        $display("FAIL linear_probe_hash_table_core");
        $finish;
    end

    function automatic t_key make_key(input logic [REGION_W-1:0] region,
                                      input logic [LETTERS_W-1:0] letters,
                                      input logic [SER_W-1:0] serial);
        return {region, letters, serial};
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Apply one request to the shadow table and return the outcome it yields
    function automatic t_outcome apply_table_request(input t_action act, input t_key key);
        t_outcome res;
        int home;
        int p;
        bit hit;
        home = int'(key[SER_W-1:0]) % TABLE_SLOTS;
        hit = 1'b0;
        res.slot = '0;
        res.status = (act == ACT_DELETE) ? ST_NOT_FOUND : ST_FULL;
        for (int k = 0; k < TABLE_SLOTS; k++) begin
            p = (home + k) % TABLE_SLOTS;
            if (!hit && act == ACT_DELETE && table_valid[p] && table_key[p] == key) begin
                table_valid[p] = 1'b0;
                if (table_count > 0) table_count--;
                res.slot = SLOT_OUT_W'(p);
                res.status = ST_REMOVED;
                hit = 1'b1;
            end else if (!hit && act == ACT_INSERT && !table_valid[p]) begin
                table_valid[p] = 1'b1;
                table_key[p] = key;
                table_count++;
                res.slot = SLOT_OUT_W'(p);
                res.status = ST_STORED;
                hit = 1'b1;
            end
        end
        res.count = COUNT_OUT_W'(table_count);
        return res;
    endfunction

    // Offer one request, wait for its transfer, then record the outcome
    task automatic send_request(input t_action act, input t_key key, input int gap);
        i_in_valid       <= 1'b1;
        i_action         <= act;
        i_region_code    <= key[KEY_W-1 -: REGION_W];
        i_letter_triplet <= key[SER_W +: LETTERS_W];
        i_serial_number  <= key[SER_W-1:0];
        do @(posedge i_clk); while (!o_in_ready);
        queued_outcomes.push_back(apply_table_request(act, key));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Random key: sometimes in the documented ranges, sometimes full width
    function automatic t_key fresh_key();
        logic [REGION_W-1:0]  region;
        logic [LETTERS_W-1:0] letters;
        logic [SER_W-1:0]     serial;
        region = $urandom_range(0, 1) ? REGION_W'($urandom_range(0, 99))
                                      : REGION_W'($urandom_range(0, 127));
        if ($urandom_range(0, 1))
            letters = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                       8'($urandom_range(65, 90))};
        else
            letters = LETTERS_W'($urandom);
        serial = ($urandom_range(0, 9) != 0) ? SER_W'($urandom_range(0, 999))
                                             : SER_W'($urandom_range(0, 1023));
        return make_key(region, letters, serial);
    endfunction

    // Key of a random occupied slot; the table must not be empty
    function automatic t_key stored_key();
        int start;
        int p;
        start = $urandom_range(0, TABLE_SLOTS - 1);
        for (int k = 0; k < TABLE_SLOTS; k++) begin
            p = (start + k) % TABLE_SLOTS;
            if (table_valid[p]) return table_key[p];
        end
        return '0;
    endfunction

    // Compare each result transfer with the oldest outcome waiting
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (queued_outcomes.size() == 0) begin
                $display("%0t: unexpected result slot=%0d status=%0d count=%0d",
                         $time, o_slot_index, o_status, o_occupied_count);
                error_count++;
            end else begin
                want = queued_outcomes.pop_front();
                if (o_slot_index !== want.slot) begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.slot, o_slot_index);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_occupied_count !== want.count) begin
                    $display("%0t: occupied_count expected %0d actual %0d",
                             $time, want.count, o_occupied_count);
                    error_count++;
                end
            end
        end
    end

    // Drive the result ready: random stalls, steady phases and long hold-offs on request
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge i_clk);
                sink_hold_cycles = 0;
                i_out_ready <= 1'b1;
            end else if (sink_steady || $urandom_range(0, 99) < 65) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                stall = pick_gap(1'b0);
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Fill with colliding homes, wrap, overflow, duplicates, holes and misses
    task automatic test_directed_edges();
        t_key k_zero;
        t_key k_ones;
        t_key k_a;
        t_key k_b;
        t_key k_c;
        t_key k_d;
        k_zero = make_key(7'd0, 24'd0, 10'd0);
        k_ones = make_key(7'h7F, 24'hFFFFFF, 10'h3FF);
        k_a    = make_key(7'd12, "ABC", 10'd6);
        k_b    = make_key(7'd99, "DEF", 10'd13);
        k_c    = make_key(7'd45, "XYZ", 10'd20);
        k_d    = make_key(7'd1, "QRS", 10'd999);
        send_request(ACT_INSERT, k_zero, pick_gap(1'b0));
        send_request(ACT_INSERT, k_ones, pick_gap(1'b0));
        send_request(ACT_INSERT, k_a, pick_gap(1'b0));
        send_request(ACT_INSERT, k_b, pick_gap(1'b0));
        send_request(ACT_INSERT, k_c, pick_gap(1'b0));
        send_request(ACT_INSERT, k_d, pick_gap(1'b0));
        send_request(ACT_INSERT, k_ones, pick_gap(1'b0));
        send_request(ACT_INSERT, make_key(7'd5, "MNO", 10'd500), pick_gap(1'b0));
        send_request(ACT_DELETE, k_ones, pick_gap(1'b0));
        send_request(ACT_DELETE, k_ones, pick_gap(1'b0));
        send_request(ACT_DELETE, k_ones, pick_gap(1'b0));
        send_request(ACT_DELETE, k_c, pick_gap(1'b0));
        send_request(ACT_DELETE, make_key(7'd12, "ABC", 10'd7), pick_gap(1'b0));
        send_request(ACT_DELETE, k_zero, pick_gap(1'b0));
        send_request(ACT_DELETE, k_a, pick_gap(1'b0));
        send_request(ACT_DELETE, k_b, pick_gap(1'b0));
        send_request(ACT_DELETE, k_d, pick_gap(1'b0));
        send_request(ACT_DELETE, k_a, pick_gap(1'b0));
    endtask

    // Mostly inserts of fresh keys and deletes of stored ones, plus noise
    task automatic test_random_traffic(input int n_items);
        int r;
        t_key key;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                send_request(t_action'($urandom_range(0, 1)), fresh_key(),
                             pick_gap(sender_steady));
            end else if (r < 12 && table_count > 0) begin
                key = stored_key() ^ (t_key'(1) << $urandom_range(0, KEY_W - 1));
                send_request(ACT_DELETE, key, pick_gap(sender_steady));
            end else if (table_count > 0 && r < 12 + 6 * table_count) begin
                send_request(ACT_DELETE, stored_key(), pick_gap(sender_steady));
            end else if (table_count > 0 && r > 94) begin
                send_request(ACT_INSERT, stored_key(), pick_gap(sender_steady));
            end else begin
                send_request(ACT_INSERT, fresh_key(), pick_gap(sender_steady));
            end
        end
    endtask

    // Hold off the receiver while requests keep coming, so the input stalls
    task automatic test_backpressure();
        sink_hold_cycles = 300;
        for (int i = 0; i < 16; i++) begin
            if (i % 3 == 2 && table_count > 0)
                send_request(ACT_DELETE, stored_key(), 0);
            else
                send_request(ACT_INSERT, fresh_key(), 0);
        end
    endtask

    initial begin
        error_count      = 0;
        sink_hold_cycles = 0;
        sender_steady    = 1'b0;
        sink_steady      = 1'b0;
        table_count      = 0;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            table_valid[s] = 1'b0;
            table_key[s]   = '0;
        end
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_action         <= ACT_INSERT;
        i_region_code    <= '0;
        i_letter_triplet <= '0;
        i_serial_number  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        sender_steady = 1'b1;
        sink_steady   = 1'b1;
        test_random_traffic(250);
        sender_steady = 1'b0;
        sink_steady   = 1'b0;
        test_backpressure();
        test_random_traffic(1250);

        // Drain outstanding results, then let the pipeline settle
        i_in_valid <= 1'b0;
        while (queued_outcomes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS linear_probe_hash_table_core");
        end else begin
            $display("FAIL linear_probe_hash_table_core");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/lpht_pkg.sv
src/lpht_ram.sv
src/lpht_mod.sv
src/linear_probe_hash_table_core.sv
tb/sv/testbench.sv
